### hw/rtl/tdp_pkg.sv
package tdp_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CLS_NOT_PRIME,
    CLS_PRIME,
    CLS_TEST
  } cls_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BOUND,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic valid;
    logic row_last;
    cls_t cls;
  } q_head_t;

endpackage

### hw/rtl/tdp_front.sv
module tdp_front #(
  parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         in_row_last,
  output logic                         full,
  output tdp_pkg::q_head_t             head,
  output logic [DATA_WIDTH-1:0]        head_value,
  input  logic                         head_pop
);
  import tdp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_WIDTH-1:0] value_q_r [QUEUE_DEPTH];
  logic                  last_q_r  [QUEUE_DEPTH];
  cls_t                  cls_q_r   [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] uvalue;
  cls_t                  in_cls;
  logic                  wr_en;
  logic                  rd_en;

  assign uvalue = $unsigned(in_value);

  // Negatives, zero and one are not prime; two and three need no trial divisor.
  always_comb begin
    if (uvalue[DATA_WIDTH-1] || uvalue < DATA_WIDTH'(2)) begin
      in_cls = CLS_NOT_PRIME;
    end else if (uvalue < DATA_WIDTH'(4)) begin
      in_cls = CLS_PRIME;
    end else begin
      in_cls = CLS_TEST;
    end
  end

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign wr_en = push && !full;
  assign rd_en = head_pop && (count_r != '0);

  assign head.valid    = (count_r != '0);
  assign head.row_last = last_q_r[rd_ptr_r];
  assign head.cls      = cls_q_r[rd_ptr_r];
  assign head_value    = value_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_q_r[wr_ptr_r] <= uvalue;
      last_q_r[wr_ptr_r]  <= in_row_last;
      cls_q_r[wr_ptr_r]   <= in_cls;
    end
  end

endmodule

### hw/rtl/tdp_back.sv
module tdp_back #(
  parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tdp_pkg::q_head_t             head,
  input  logic [DATA_WIDTH-1:0]        head_value,
  output logic                         head_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] out_value_out,
  output logic                         out_is_prime,
  output logic                         out_row_end
);
  import tdp_pkg::*;

  localparam int DIV_W = DATA_WIDTH / 2 + 1;
  localparam int SQ_W  = DATA_WIDTH + 1;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  bk_state_t             state_r, state_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic                  last_r, last_nxt;
  logic                  prime_r, prime_nxt;
  logic [DIV_W-1:0]      div_r, div_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIV_W:0]        rem_shift;
  logic [DIV_W-1:0]      rem_step;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    rem_shift = {rem_r, sh_r[DATA_WIDTH-1]};
    if (rem_shift >= {1'b0, div_r}) begin
      rem_step = DIV_W'(rem_shift - {1'b0, div_r});
    end else begin
      rem_step = rem_shift[DIV_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    prime_nxt = prime_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    head_pop  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          head_pop  = 1'b1;
          value_nxt = head_value;
          last_nxt  = head.row_last;
          prime_nxt = (head.cls == CLS_PRIME);
          div_nxt   = DIV_W'(2);
          sq_nxt    = SQ_W'(4);
          state_nxt = (head.cls == CLS_TEST) ? BK_BOUND : BK_DONE;
        end
      end
      BK_BOUND: begin
        if (sq_r > {1'b0, value_r}) begin
          prime_nxt = 1'b1;
          state_nxt = BK_DONE;
        end else begin
          rem_nxt   = '0;
          sh_nxt    = value_r;
          cnt_nxt   = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt = rem_step;
        sh_nxt  = {sh_r[DATA_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          if (rem_step == '0) begin
            prime_nxt = 1'b0;
            state_nxt = BK_DONE;
          end else begin
            // (d + 1) squared is d squared plus 2d + 1.
            sq_nxt    = sq_r + SQ_W'({div_r, 1'b1});
            div_nxt   = div_r + DIV_W'(1);
            state_nxt = BK_BOUND;
          end
        end
      end
      BK_DONE: begin
        if (!out_valid_r || pop) begin
          out_load  = 1'b1;
          div_nxt   = DIV_W'(2);
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      div_r       <= DIV_W'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_r       <= div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    last_r  <= last_nxt;
    prime_r <= prime_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    sh_r    <= sh_nxt;
    cnt_r   <= cnt_nxt;
    if (out_load) begin
      out_value_out <= $signed(value_r);
      out_is_prime  <= prime_r;
      out_row_end   <= last_r;
    end
  end

  a_div_within_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> sq_r <= {1'b0, value_r})
    else $error("Trial division running past the square bound.");

  a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_BOUND || state_r == BK_DIV) |-> div_r >= DIV_W'(2))
    else $error("Trial divisor below two.");

  a_negative_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && value_r[DATA_WIDTH-1] |=> !out_is_prime)
    else $error("Negative value reported as prime.");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> state_r != BK_IDLE)
    else $error("Queue entry taken but no work started.");

endmodule

### hw/rtl/trial_division_prime_test.sv
// Channel  Transfer when       Ports
// input    push && !full       in_value, in_row_last
// result   pop && !empty       out_value_out, out_is_prime, out_row_end
//
// A value that is negative or below four needs no trial division. Otherwise each trial
// divisor from two upward takes one pass through the one-bit-per-cycle remainder unit,
// until the divisor's square exceeds the value or a remainder of zero is found.
// Reset is synchronous and active low; it empties the input queue and result slot.
// A two-entry queue takes items while the back end works; a waiting result stalls only
// the back end, never the input side until the queue is full.
module trial_division_prime_test #(
  parameter int DATA_WIDTH = tdp_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         in_row_last,
  output logic                         full,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] out_value_out,
  output logic                         out_is_prime,
  output logic                         out_row_end
);
  import tdp_pkg::*;

  q_head_t               head;
  logic [DATA_WIDTH-1:0] head_value;
  logic                  head_pop;

  tdp_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_value   (in_value),
    .in_row_last(in_row_last),
    .full       (full),
    .head       (head),
    .head_value (head_value),
    .head_pop   (head_pop)
  );

  tdp_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .head_value   (head_value),
    .head_pop     (head_pop),
    .empty        (empty),
    .pop          (pop),
    .out_value_out(out_value_out),
    .out_is_prime (out_is_prime),
    .out_row_end  (out_row_end)
  );

endmodule
